/* rtl/dvc_pkg.sv */
// Shared types and constants of the block distinct-value counter.
package dvc_pkg;

	localparam int PC_W      = 64;
	localparam int LIMIT_W   = 10;
	localparam int COUNT_W   = 10;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int EPOCH_W   = 8;
	localparam int MIX_SHIFT = 29;
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = PC_W / MOD_DIGIT;

	localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 10'd512;
	localparam logic [PC_W-1:0]      HASH_MULT   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [EPOCH_W-1:0]   EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0]   EPOCH_LAST  = 8'hFF;

	// register index is the word address, paddr[ADDR_W-1:2]
	localparam logic [ADDR_W-3:0] REG_BLOCK_LIMIT = 1'b0;

	typedef struct packed {
		logic [PC_W-1:0] pc_value;
		logic            sequence_end;
	} rec_beat_t;

	typedef struct packed {
		logic [COUNT_W-1:0] distinct_count;
		logic [COUNT_W-1:0] records_in_block;
	} res_beat_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [PC_W-1:0]    value;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_CLOSE
	} dvc_state_t;

	typedef enum logic [2:0] {
		HS_IDLE,
		HS_CROSS1,
		HS_CROSS2,
		HS_MIX,
		HS_MOD,
		HS_DONE
	} hash_step_t;

endpackage

/* rtl/dvc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dvc_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/dvc_hash.sv */
// Multi-cycle home-slot hash: 64-bit multiply on a shared 32x32 unit, xor-shift, modulo.
module dvc_hash import dvc_pkg::*; #(
	parameter int SLOTS = 1024,
	localparam int SW = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [PC_W-1:0] value,
	output logic            done,
	output logic [SW-1:0]   slot
);

	localparam bit            IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [SW:0]   MOD_T    = (SW + 1)'(SLOTS);
	localparam int            DIG_W    = $clog2(MOD_STEPS);
	localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(MOD_STEPS - 1);

	hash_step_t        step_q, step_d;
	logic [PC_W-1:0]   v_q, acc_q, h_q, mix;
	logic [SW:0]       r_q, r_next;
	logic [DIG_W-1:0]  dig_q;
	logic [SW-1:0]     slot_q;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       mul_p;

	// low 64 bits of v*K = lo*lo + ((hi*lo + lo*hi) << 32)
	always_comb begin
		case (step_q)
			HS_IDLE: begin
				mul_a = value[31:0];
				mul_b = HASH_MULT[31:0];
			end
			HS_CROSS1: begin
				mul_a = v_q[63:32];
				mul_b = HASH_MULT[31:0];
			end
			HS_CROSS2: begin
				mul_a = v_q[31:0];
				mul_b = HASH_MULT[63:32];
			end
			default: begin
				mul_a = v_q[31:0];
				mul_b = HASH_MULT[31:0];
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign mix   = acc_q ^ (acc_q >> MIX_SHIFT);

	// remainder, MOD_DIGIT bits per cycle, msb first
	always_comb begin
		logic [SW:0] r_tmp;
		r_tmp = r_q;
		for (int i = 0; i < MOD_DIGIT; i++) begin
			r_tmp = {r_tmp[SW-1:0], h_q[PC_W-1-i]};
			if (r_tmp >= MOD_T) begin
				r_tmp = r_tmp - MOD_T;
			end
		end
		r_next = r_tmp;
	end

	always_comb begin
		step_d = step_q;
		case (step_q)
			HS_IDLE: begin
				if (start) begin
					step_d = HS_CROSS1;
				end
			end
			HS_CROSS1: step_d = HS_CROSS2;
			HS_CROSS2: step_d = HS_MIX;
			HS_MIX:    step_d = IS_POW2 ? HS_DONE : HS_MOD;
			HS_MOD: begin
				if (dig_q == DIG_LAST) begin
					step_d = HS_DONE;
				end
			end
			HS_DONE:   step_d = HS_IDLE;
			default:   step_d = HS_IDLE;
		endcase
	end

	always_comb begin
		done = (step_q == HS_DONE);
		slot = slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= HS_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			HS_IDLE: begin
				if (start) begin
					v_q   <= value;
					acc_q <= mul_p;
				end
			end
			HS_CROSS1, HS_CROSS2: begin
				acc_q[63:32] <= acc_q[63:32] + mul_p[31:0];
			end
			HS_MIX: begin
				h_q    <= mix;
				r_q    <= '0;
				dig_q  <= '0;
				slot_q <= mix[SW-1:0];
			end
			HS_MOD: begin
				h_q   <= h_q << MOD_DIGIT;
				r_q   <= r_next;
				dig_q <= dig_q + 1'b1;
				if (dig_q == DIG_LAST) begin
					slot_q <= r_next[SW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/block_distinct_value_counter_core.sv */
// Top level of the block distinct-value counter: config regs, probe sequencer, result register.
//
//  channel | handshake           | payload              | direction
//  --------+---------------------+----------------------+----------
//  rec     | rec_valid/rec_ready | rec_beat_t rec_data  | in
//  res     | res_valid/res_ready | res_beat_t res_data  | out
//  apb     | psel/penable/pready | paddr/pwdata/prdata  | config
//
// One record at a time. A record passes through these steps in order:
// accept, which is the first of three steps on the shared 32x32 multiplier,
// a mix step (then modulo steps when TABLE_SLOTS is not a power of two), a
// done step, one slot read and compare per probe, a counter update.
// After reset, and again after every 255th closed block, a sweep rewrites
// every slot's epoch tag; no record is taken then, config writes still are.
// A closing record waits in the close step while the result register holds
// a beat not yet taken; otherwise a waiting beat does not stall records.
module block_distinct_value_counter_core import dvc_pkg::*; #(
	parameter int MAX_BLOCK   = 512,
	parameter int TABLE_SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// record channel
	input  logic              rec_valid,
	output logic              rec_ready,
	input  rec_beat_t         rec_data,
	// result channel
	output logic              res_valid,
	input  logic              res_ready,
	output res_beat_t         res_data
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(MAX_BLOCK + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [SW-1:0] SLOT_LAST = SW'(TABLE_SLOTS - 1);
	localparam logic [LW-1:0] MAX_LIM   = LW'(MAX_BLOCK);
	localparam logic [LW-1:0] MIN_LIM   = LW'(1);

	// ---------------- config ----------------
	logic [LIMIT_W-1:0] limit_q;
	logic [ADDR_W-3:0]  reg_idx;
	logic               cfg_wr;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_BLOCK_LIMIT) ? DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && reg_idx == REG_BLOCK_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// effective limit: zero acts as one, saturate at MAX_BLOCK
	logic [LW-1:0] lim_ext, eff_limit;
	always_comb begin
		lim_ext = LW'(limit_q);
		if (lim_ext == '0) begin
			eff_limit = MIN_LIM;
		end else if (lim_ext > MAX_LIM) begin
			eff_limit = MAX_LIM;
		end else begin
			eff_limit = lim_ext;
		end
	end

	// ---------------- state ----------------
	dvc_state_t         state_q, state_d;
	logic [SW-1:0]      sweep_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CW-1:0]      pos_q, dist_q;
	logic               out_valid_q;
	res_beat_t          out_data_q;

	// per-record working registers
	logic [PC_W-1:0]    pc_q;
	logic               last_q;
	logic [SW-1:0]      slot_q, probes_q;
	logic               new_q;

	// ---------------- hash unit ----------------
	logic          hash_start, hash_done;
	logic [SW-1:0] hash_slot;

	dvc_hash #(
		.SLOTS(TABLE_SLOTS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.value (rec_data.pc_value),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	// ---------------- slot table ----------------
	// Each entry carries the epoch of the block that wrote it; an entry is
	// live only when its tag equals the current epoch, so a block close
	// empties the set by bumping the epoch.
	logic          ram_we, ram_re;
	logic [SW-1:0] ram_waddr, ram_raddr;
	slot_entry_t   ram_wdata, rd_entry;

	dvc_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_entry)
	);

	logic          slot_free, slot_match, probe_end;
	logic [SW-1:0] next_slot;

	assign slot_free  = (rd_entry.epoch != epoch_q);
	assign slot_match = (rd_entry.value == pc_q);
	assign probe_end  = (probes_q == SLOT_LAST);
	assign next_slot  = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

	// ---------------- close bookkeeping ----------------
	logic [CW-1:0] count_next, dist_next;
	logic          close_now, res_free, commit;

	assign count_next = pos_q + 1'b1;
	assign dist_next  = dist_q + CW'(new_q);
	assign close_now  = last_q || (LW'(count_next) >= eff_limit);
	assign res_free   = !out_valid_q || res_ready;
	assign commit     = (state_q == ST_CLOSE) && (!close_now || res_free);

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == SLOT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (rec_valid) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (slot_free || slot_match || probe_end) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (commit) begin
					if (close_now && epoch_q == EPOCH_LAST) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		rec_ready  = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = slot_q;
		ram_wdata  = '{epoch: epoch_q, value: pc_q};
		ram_re     = 1'b0;
		ram_raddr  = next_slot;
		case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				rec_ready = 1'b1;
			end
			ST_HASH: begin
				ram_re    = hash_done;
				ram_raddr = hash_slot;
			end
			ST_PROBE: begin
				if (slot_free) begin
					ram_we = 1'b1;
				end else if (!slot_match && !probe_end) begin
					ram_re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign hash_start = rec_valid && rec_ready;
	assign res_valid  = out_valid_q;
	assign res_data   = out_data_q;

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			epoch_q     <= EPOCH_FIRST;
			pos_q       <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				sweep_q <= (sweep_q == SLOT_LAST) ? '0 : sweep_q + 1'b1;
			end
			// a new beat may load in the cycle the old one is taken
			if (commit && close_now) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				if (close_now) begin
					pos_q       <= '0;
					dist_q      <= '0;
					epoch_q     <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
				end else begin
					pos_q  <= count_next;
					dist_q <= dist_next;
				end
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (hash_start) begin
			pc_q   <= rec_data.pc_value;
			last_q <= rec_data.sequence_end;
		end
		if (state_q == ST_HASH && hash_done) begin
			slot_q   <= hash_slot;
			probes_q <= '0;
		end
		if (state_q == ST_PROBE) begin
			if (slot_free) begin
				new_q <= 1'b1;
			end else if (slot_match || probe_end) begin
				// already present, or table full: not counted
				new_q <= 1'b0;
			end else begin
				slot_q   <= next_slot;
				probes_q <= probes_q + 1'b1;
			end
		end
		if (commit && close_now) begin
			out_data_q.distinct_count   <= COUNT_W'(dist_next);
			out_data_q.records_in_block <= COUNT_W'(count_next);
		end
	end

endmodule

/* rtl/dvc_checker.sv */
// Port-level checks of the distinct-value counter, bound to its top level.
module dvc_checker import dvc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rec_valid,
	input logic      rec_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_beat_t res_data
);

	// a result beat held under backpressure keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// a closed block holds at least one record and no more distinct values than records
	a_res_sane: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.records_in_block != '0 && res_data.distinct_count != '0
			&& res_data.distinct_count <= res_data.records_in_block)
		else $error("result beat counts inconsistent");

	// one record in flight: no acceptance in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_ready |=> !rec_ready)
		else $error("record accepted while another is in flight");

	// quiet during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid && !rec_ready)
		else $error("handshake active during reset");

endmodule

bind block_distinct_value_counter_core dvc_checker u_dvc_checker (.*);

/* sim/tb_top.sv */
// Testbench for the block distinct-value counter: directed and random record streams.
`timescale 1ns / 1ps

module tb_top;
	import dvc_pkg::*;

	localparam int MAX_BLOCK   = 512;
	localparam int TABLE_SLOTS = 1024;
	// quiet wait at the end of settle for a record still in the pipe
	localparam int QUIET_CYCLES = 200;
	// long receiver hold-off used to back the block up
	localparam int HOLD_LEN     = 300;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              rec_valid = 1'b0;
	logic              rec_ready;
	rec_beat_t         rec_data  = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	res_beat_t         res_data;

	block_distinct_value_counter_core #(
		.MAX_BLOCK  (MAX_BLOCK),
		.TABLE_SLOTS(TABLE_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec_data (rec_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	// records waiting to be offered, filled by the stimulus process
	rec_beat_t   pending_recs[$];
	// block results the counter owes us, oldest first
	res_beat_t   expected_counts[$];
	int unsigned recs_pushed = 0;
	int unsigned recs_taken  = 0;
	int unsigned bad_beats   = 0;

	// idle rates in percent, switched per traffic mode
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// receiver hold-off control
	bit          long_hold_req = 1'b0;
	bit          hold_done     = 1'b0;
	int unsigned hold_cycles   = 0;

	// shadow of the block-length register and of the open block
	logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
	bit                 pcs_in_block[bit [PC_W-1:0]];
	int unsigned        open_records  = 0;
	int unsigned        open_distinct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Zero closes every record, anything past MAX_BLOCK saturates.
	function automatic int unsigned block_cap(logic [LIMIT_W-1:0] lim);
		if (lim == 0)
			return 1;
		if (lim > MAX_BLOCK)
			return MAX_BLOCK;
		return lim;
	endfunction

	// Fold one accepted record into the open block; queue a result on close.
	task automatic count_record(rec_beat_t r);
		res_beat_t closed;
		open_records++;
		if (!pcs_in_block.exists(r.pc_value)) begin
			pcs_in_block[r.pc_value] = 1'b1;
			open_distinct++;
		end
		if (r.sequence_end || open_records >= block_cap(cfg_limit)) begin
			closed.distinct_count   = open_distinct[COUNT_W-1:0];
			closed.records_in_block = open_records[COUNT_W-1:0];
			expected_counts = {expected_counts, closed};
			pcs_in_block.delete();
			open_records  = 0;
			open_distinct = 0;
		end
	endtask

	// ---------------------------------------------------------------
	// Record driver: a new beat goes out only once the current one is
	// taken (or none is up), so valid and payload hold until accepted.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (!rec_valid || rec_ready) begin
			if (pending_recs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				rec_data  <= pending_recs.pop_front();
				rec_valid <= 1'b1;
			end else begin
				rec_valid <= 1'b0;
			end
		end
	end

	// Accepted records feed the predictor.
	always @(posedge clk) begin
		if (arst_n && rec_valid && rec_ready) begin
			count_record(rec_data);
			recs_taken++;
		end
	end

	// ---------------------------------------------------------------
	// Result side: random ready, with one long hold-off on request so
	// the result register fills and the closing record backs up the
	// record channel.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (long_hold_req && !hold_done) begin
			res_ready   <= 1'b0;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles == HOLD_LEN - 1)
				hold_done <= 1'b1;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Result checker: every beat must match the oldest expected count pair.
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_counts.size() == 0) begin
				$error("result beat with nothing expected: distinct_count %0d records_in_block %0d",
					res_data.distinct_count, res_data.records_in_block);
				bad_beats++;
			end else begin
				want = expected_counts.pop_front();
				if (res_data.distinct_count !== want.distinct_count) begin
					$error("distinct_count: expected %0d, got %0d",
						want.distinct_count, res_data.distinct_count);
					bad_beats++;
				end
				if (res_data.records_in_block !== want.records_in_block) begin
					$error("records_in_block: expected %0d, got %0d",
						want.records_in_block, res_data.records_in_block);
					bad_beats++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_rec(logic [PC_W-1:0] pc, logic last);
		rec_beat_t r;
		r.pc_value     = pc;
		r.sequence_end = last;
		pending_recs = {pending_recs, r};
		recs_pushed++;
	endtask

	// Wait until every record is taken and every result is back, then give
	// any non-closing record still in the pipe time to finish.
	task automatic settle();
		do
			@(negedge clk);
		while (recs_taken != recs_pushed || expected_counts.size() != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Register write through the APB port, only ever with the block idle.
	task automatic write_limit(logic [DATA_W-1:0] word);
		settle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_BLOCK_LIMIT, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_limit = word[LIMIT_W-1:0];
	endtask

	// One sequence: PCs mostly from a small loop-like pool so values repeat,
	// with the odd far jump; the last record carries sequence_end.
	task automatic send_sequence(int unsigned len, int unsigned pool);
		logic [PC_W-1:0] base;
		logic [PC_W-1:0] pc;
		base = {$urandom, $urandom};
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				pc = {$urandom, $urandom};
			else
				pc = base + 64'(4 * $urandom_range(0, pool - 1));
			push_rec(pc, i == len - 1);
		end
	endtask

	// Noise: random PCs, sequence_end set at random.
	task automatic send_noise(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_rec({$urandom, $urandom}, $urandom_range(0, 3) == 0);
	endtask

	task automatic random_traffic(int unsigned total, int unsigned max_len);
		int unsigned n;
		int unsigned len;
		n = 0;
		while (n < total) begin
			len = $urandom_range(1, max_len);
			if ($urandom_range(0, 7) == 0)
				send_noise(len);
			else
				send_sequence(len, $urandom_range(1, len));
			n += len;
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, limit at its reset value of 512; slow receiver.
		send_idle_pct = 13;
		recv_idle_pct = 80;
		push_rec(64'h0, 1'b1);                      // one-record sequence, zero PC
		push_rec('1, 1'b1);                         // all-ones PC
		push_rec(64'h0, 1'b0);
		push_rec('1, 1'b0);
		push_rec(64'h0, 1'b0);
		push_rec('1, 1'b1);                         // two distinct over four records
		repeat (5) push_rec(64'h1000, 1'b0);
		push_rec(64'h1000, 1'b1);                   // one value repeated
		push_rec(64'h8000_0000_0000_0000, 1'b0);
		push_rec(64'h1, 1'b0);
		push_rec(64'h8000_0000_0000_0000, 1'b1);
		push_rec(64'h5555_5555_5555_5555, 1'b0);
		push_rec(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

		// zero limit acts as one: every record is its own block
		write_limit(32'd0);
		push_rec(64'h7, 1'b0);
		push_rec(64'h7, 1'b0);

		// short limit closes without sequence_end
		write_limit(32'd3);
		push_rec(64'hA0, 1'b0);
		push_rec(64'hB0, 1'b0);
		push_rec(64'hA0, 1'b0);

		// saturated limit, then shrink it under an open block of four
		write_limit(32'd1023);
		push_rec(64'h100, 1'b0);
		push_rec(64'h200, 1'b0);
		push_rec(64'h100, 1'b0);
		push_rec(64'h300, 1'b0);
		write_limit(32'd2);
		push_rec(64'h400, 1'b0);                    // length 5 passes the new limit

		// Random, mode A: slow receiver.
		send_idle_pct = 13;
		recv_idle_pct = 80;
		// junk above the field must be dropped
		write_limit({22'($urandom), 10'd16});
		random_traffic(60, 40);

		// Random, mode B: slow sender.
		send_idle_pct = 80;
		recv_idle_pct = 13;
		write_limit(32'd512);
		random_traffic(60, 30);
		// receiver stalls for a long stretch while records keep coming
		write_limit(32'd2);
		long_hold_req = 1'b1;
		random_traffic(30, 4);

		// Random, mode C: no idling. Many closes here push the block past
		// its epoch wrap and through the re-tagging sweep.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(32'd0);
		random_traffic(150, 6);
		write_limit(32'd1);
		random_traffic(100, 6);
		write_limit(32'd7);
		random_traffic(40, 12);

		settle();
		if (bad_beats == 0 && expected_counts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
